### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro takes a label, a condition, a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the condition
`define ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the condition
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lprt_pkg.sv
package lprt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_FIND   = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // One stored route
    typedef struct packed {
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  iface;
        logic [4:0]  metric;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    // Request payload
    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  iface_id;
        logic [4:0]  metric;
        logic [4:0]  slot;
        logic [31:0] lookup_addr;
    } request_t;

    // Result payload
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_index;
        logic [31:0] route_subnet;
        logic [31:0] route_mask;
        logic [31:0] route_gateway;
        logic [3:0]  route_iface;
        logic [4:0]  route_metric;
        logic [5:0]  match_len;
    } result_t;

    // Search key presented to the comparer
    typedef struct packed {
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [31:0] lookup_addr;
    } match_key_t;

    // Comparer verdict for one slot
    typedef struct packed {
        logic       exact_hit;
        logic       prefix_hit;
        logic [5:0] plen;
    } match_t;

    // Route RAM control from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        route_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_ctl_t;

    // Prefix bits contributed by one mask byte
    function automatic logic [3:0] byte_prefix(input logic [7:0] b);
        logic [3:0] n;
        unique case (b)
            8'd255:  n = 4'd8;
            8'd254:  n = 4'd7;
            8'd252:  n = 4'd6;
            8'd248:  n = 4'd5;
            8'd240:  n = 4'd4;
            8'd224:  n = 4'd3;
            8'd192:  n = 4'd2;
            8'd128:  n = 4'd1;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Prefix length of a mask, summed byte by byte
    function automatic logic [5:0] mask_prefix(input logic [31:0] m);
        return {2'b00, byte_prefix(m[31:24])} + {2'b00, byte_prefix(m[23:16])}
             + {2'b00, byte_prefix(m[15:8])}  + {2'b00, byte_prefix(m[7:0])};
    endfunction

endpackage

### rtl/core/lprt_ram.sv
module lprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/lprt_match.sv
module lprt_match (
    input  lprt_pkg::route_t     entry,
    input  lprt_pkg::match_key_t key,
    output lprt_pkg::match_t     match
);
    import lprt_pkg::*;

    // Shared comparer: exact pair test, prefix test and prefix length
    always_comb
    begin
        match.exact_hit  = (entry.subnet == key.subnet) && (entry.mask == key.mask);
        match.prefix_hit = ((key.lookup_addr & entry.mask) == entry.subnet);
        match.plen       = mask_prefix(entry.mask);
    end

endmodule

### rtl/core/lprt_seq.sv
module lprt_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  lprt_pkg::request_t   request,
    input  lprt_pkg::route_t     rd_data,
    input  lprt_pkg::match_t     match,
    output logic                 busy,
    output logic                 done,
    output lprt_pkg::result_t    result,
    output lprt_pkg::match_key_t key,
    output lprt_pkg::ram_ctl_t   ram_ctl
);
    import lprt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SLOT,
        S_READ,
        S_SCAN,
        S_DRAIN,
        S_NONE
    } state_t;

    state_t                   state_reg, state_next;
    request_t                 req_reg, req_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;
    logic                     cmp_en_reg, cmp_en_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     found_reg, found_next;
    logic [5:0]               best_len_reg, best_len_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    route_t                   best_route_reg, best_route_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;

    logic [IDX_W-1:0]         slot_idx;
    logic                     slot_ok;
    logic                     cmp_valid;
    logic                     better;
    logic                     exact;
    route_t                   req_route;

    // Result word for a returned slot
    function automatic result_t mk_result(input route_t r, input logic [IDX_W-1:0] idx,
                                          input logic [5:0] plen);
        result_t o;
        o.status        = ST_OK;
        o.entry_index   = 5'(idx);
        o.route_subnet  = r.subnet;
        o.route_mask    = r.mask;
        o.route_gateway = r.gateway;
        o.route_iface   = r.iface;
        o.route_metric  = r.metric;
        o.match_len     = plen;
        return o;
    endfunction

    // Result word carrying a status only
    function automatic result_t mk_status(input logic [1:0] st);
        result_t o;
        o        = '0;
        o.status = st;
        return o;
    endfunction

    // Request decode and comparer qualification
    always_comb
    begin
        slot_idx  = IDX_W'(req_reg.slot);
        slot_ok   = (32'(req_reg.slot) < 32'(TABLE_ENTRIES)) && valid_reg[slot_idx];
        cmp_valid = cmp_en_reg && valid_reg[cmp_idx_reg];
        exact     = cmp_valid && match.exact_hit;
        better    = cmp_valid && match.prefix_hit && (!found_reg || (match.plen > best_len_reg));

        req_route.subnet  = req_reg.subnet;
        req_route.mask    = req_reg.mask;
        req_route.gateway = req_reg.gateway;
        req_route.iface   = req_reg.iface_id;
        req_route.metric  = req_reg.metric;

        key.subnet      = req_reg.subnet;
        key.mask        = req_reg.mask;
        key.lookup_addr = req_reg.lookup_addr;
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        scan_next       = scan_reg;
        cmp_en_next     = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        best_idx_next   = best_idx_reg;
        best_route_next = best_route_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = scan_reg;
        ram_ctl.wdata = req_route;
        ram_ctl.raddr = scan_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    scan_next  = '0;
                    found_next = 1'b0;
                    unique case (request.command)
                        CMD_ADD:    state_next = S_ADD;
                        CMD_REMOVE: state_next = S_SLOT;
                        CMD_GET:    state_next = S_SLOT;
                        CMD_FIND:   state_next = S_SCAN;
                        CMD_LOOKUP: state_next = S_SCAN;
                        default:    state_next = S_NONE;
                    endcase
                end
            end

            // Lowest free slot, one valid bit a cycle
            S_ADD:
            begin
                if (!valid_reg[scan_reg])
                begin
                    ram_ctl.we           = 1'b1;
                    valid_next[scan_reg] = 1'b1;
                    result_next          = mk_result(req_route, scan_reg, 6'd0);
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    result_next = mk_status(ST_FULL);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Indexed access: check the slot and issue the read
            S_SLOT:
            begin
                ram_ctl.raddr = slot_idx;
                if (slot_ok)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    result_next = mk_status(ST_NONE);
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_READ:
            begin
                result_next = mk_result(rd_data, slot_idx, 6'd0);
                done_next   = 1'b1;
                state_next  = S_IDLE;
                if (req_reg.command == CMD_REMOVE)
                begin
                    valid_next[slot_idx] = 1'b0;
                end
            end

            // Scan: read slot n while slot n-1 is compared
            S_SCAN:
            begin
                ram_ctl.raddr = scan_reg;
                cmp_en_next   = 1'b1;
                cmp_idx_next  = scan_reg;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end

                if (req_reg.command == CMD_FIND)
                begin
                    if (exact)
                    begin
                        result_next = mk_result(rd_data, cmp_idx_reg, 6'd0);
                        done_next   = 1'b1;
                        cmp_en_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
                else if (better)
                begin
                    found_next      = 1'b1;
                    best_len_next   = match.plen;
                    best_idx_next   = cmp_idx_reg;
                    best_route_next = rd_data;
                end
            end

            // Last compare, then report
            S_DRAIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (req_reg.command == CMD_FIND)
                begin
                    result_next = exact ? mk_result(rd_data, cmp_idx_reg, 6'd0)
                                        : mk_status(ST_NONE);
                end
                else if (better)
                begin
                    result_next = mk_result(rd_data, cmp_idx_reg, match.plen);
                end
                else if (found_reg)
                begin
                    result_next = mk_result(best_route_reg, best_idx_reg, best_len_reg);
                end
                else
                begin
                    result_next = mk_status(ST_NONE);
                end
            end

            S_NONE:
            begin
                result_next = mk_status(ST_NONE);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmp_en_reg     <= 1'b0;
            found_reg      <= 1'b0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            req_reg        <= '0;
            scan_reg       <= '0;
            cmp_idx_reg    <= '0;
            best_len_reg   <= '0;
            best_idx_reg   <= '0;
            best_route_reg <= '0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_en_reg     <= cmp_en_next;
            found_reg      <= found_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            req_reg        <= req_next;
            scan_reg       <= scan_next;
            cmp_idx_reg    <= cmp_idx_next;
            best_len_reg   <= best_len_next;
            best_idx_reg   <= best_idx_next;
            best_route_reg <= best_route_next;
            result_reg     <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/longest_prefix_route_table.sv
// IPv4 route table with longest-prefix lookup.
// A request is taken on a rising edge with start high and busy low; the
// request struct carries the command and its operands. Busy stays high
// while the request runs. The result struct is valid for exactly one cycle
// with done high and must be taken then: the receiver cannot stall.
// Add stops at the lowest free slot, find at the first exact hit, and
// lookup walks every slot.
// Find and lookup walk the slots one per cycle through the single read
// port of the route RAM and the one shared comparer, add walks the valid
// bits one per cycle, and the next request may start in the done cycle.
// Reset clears all valid bits at once; route contents are undefined until
// written and are never returned for an empty slot. No clearing pass.
module longest_prefix_route_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lprt_pkg::request_t request,
    output logic               done,
    output lprt_pkg::result_t  result
);
    import lprt_pkg::*;

`include "assert_macros.svh"

    ram_ctl_t             ram_ctl;
    logic [ROUTE_W-1:0]   rd_raw;
    route_t               rd_data;
    match_key_t           key;
    match_t               match;

    // Route storage
    lprt_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_ctl.we),
        .waddr (ram_ctl.waddr),
        .wdata (ram_ctl.wdata),
        .raddr (ram_ctl.raddr),
        .rdata (rd_raw)
    );

    assign rd_data = route_t'(rd_raw);

    // Shared comparer
    lprt_match u_match (
        .entry (rd_data),
        .key   (key),
        .match (match)
    );

    // Command sequencer
    lprt_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .rd_data (rd_data),
        .match   (match),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .key     (key),
        .ram_ctl (ram_ctl)
    );

    // Checks
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
    `ASSERT_SAME(a_status_code, done, (result.status == ST_OK) || (result.status == ST_FULL) || (result.status == ST_NONE), "undefined status code")
    `ASSERT_SAME(a_write_busy, ram_ctl.we, busy, "route RAM written while idle")

endmodule

### verif/longest_prefix_route_table_tb.sv
`timescale 1ns / 100ps

module longest_prefix_route_table_tb;

    import lprt_pkg::*;

    localparam int RANDOM_REQUESTS = 1400;
    localparam int SETTLE_CYCLES   = TABLE_ENTRIES + 8;  // longest request plus margin
    localparam int CYCLE_LIMIT     = 400000;
    localparam int QUIET_FIRST     = 500;                // random requests sent without gaps
    localparam int QUIET_LAST      = 899;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    // Directed stimulus row; want is only used where typed is set
    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } stim_row_t;

    stim_row_t directed_rows[$];
    result_t   pending_results[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // Predictor copy of the route table
    bit [TABLE_ENTRIES-1:0] tbl_valid;
    route_t                 tbl_route [TABLE_ENTRIES];
    bit                     draining;

    longest_prefix_route_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    endtask

    function automatic request_t make_req(logic [2:0] cmd, logic [31:0] sub, logic [31:0] msk,
                                          logic [31:0] nh, logic [3:0] ifc, logic [4:0] met,
                                          logic [4:0] sl, logic [31:0] addr);
        request_t r;
        r.command     = cmd;
        r.subnet      = sub;
        r.mask        = msk;
        r.gateway     = nh;
        r.iface_id    = ifc;
        r.metric      = met;
        r.slot        = sl;
        r.lookup_addr = addr;
        return r;
    endfunction

    function automatic result_t make_res(logic [1:0] st, logic [4:0] idx, route_t rt,
                                          logic [5:0] plen);
        result_t s;
        s.status        = st;
        s.entry_index   = idx;
        s.route_subnet  = rt.subnet;
        s.route_mask    = rt.mask;
        s.route_gateway = rt.gateway;
        s.route_iface   = rt.iface;
        s.route_metric  = rt.metric;
        s.match_len     = plen;
        return s;
    endfunction

    // Prefix bits: each mask byte of the form ones-then-zeros adds its ones
    function automatic logic [5:0] prefix_bits(logic [31:0] m);
        int         total;
        logic [7:0] b;
        total = 0;
        for (int k = 0; k < 4; k++) begin
            b = m[8*k +: 8];
            for (int n = 1; n <= 8; n++)
                if (b == 8'(8'hFF << (8 - n)))
                    total += n;
        end
        return 6'(total);
    endfunction

    // Work out the result of one request and update the table copy
    function automatic result_t route_table_apply(request_t r);
        result_t    res;
        route_t     nr;
        bit         found;
        int         best;
        logic [5:0] best_len;
        logic [5:0] len;
        res = make_res(ST_NONE, '0, '0, '0);
        case (r.command)
            CMD_ADD:
            begin
                res.status = ST_FULL;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!tbl_valid[i]) begin
                        nr.subnet    = r.subnet;
                        nr.mask      = r.mask;
                        nr.gateway   = r.gateway;
                        nr.iface     = r.iface_id;
                        nr.metric    = r.metric;
                        tbl_valid[i] = 1'b1;
                        tbl_route[i] = nr;
                        res = make_res(ST_OK, 5'(i), nr, '0);
                        break;
                    end
                end
            end
            CMD_REMOVE, CMD_GET:
            begin
                if (tbl_valid[r.slot]) begin
                    res = make_res(ST_OK, r.slot, tbl_route[r.slot], '0);
                    if (r.command == CMD_REMOVE)
                        tbl_valid[r.slot] = 1'b0;
                end
            end
            CMD_FIND:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_route[i].subnet == r.subnet
                            && tbl_route[i].mask == r.mask) begin
                        res = make_res(ST_OK, 5'(i), tbl_route[i], '0);
                        break;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                found    = 1'b0;
                best     = 0;
                best_len = '0;
                // strict compare keeps the lower slot on a tie
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i]
                            && (r.lookup_addr & tbl_route[i].mask) == tbl_route[i].subnet) begin
                        len = prefix_bits(tbl_route[i].mask);
                        if (!found || len > best_len) begin
                            found    = 1'b1;
                            best     = i;
                            best_len = len;
                        end
                    end
                end
                if (found)
                    res = make_res(ST_OK, 5'(best), tbl_route[best], best_len);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Random valid slot, or -1 when the table is empty
    function automatic int pick_valid_slot();
        int live[$];
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Leading address byte drawn from a few networks so that prefixes overlap
    function automatic logic [7:0] pick_top();
        case ($urandom_range(0, 3))
            0:       return 8'd10;
            1:       return 8'd172;
            2:       return 8'd192;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random request, shaped by what the table currently holds
    function automatic request_t next_random_request();
        request_t    r;
        int          used;
        int          pick;
        int          v;
        logic [31:0] msk;
        r = make_req(3'($urandom), $urandom, $urandom, $urandom, 4'($urandom),
                     5'($urandom_range(0, 16)), 5'($urandom), $urandom);
        used = $countones(tbl_valid);
        if (used == TABLE_ENTRIES && $urandom_range(0, 3) == 0)
            draining = 1'b1;
        if (used <= 2)
            draining = 1'b0;
        pick = $urandom_range(0, 99);
        v    = pick_valid_slot();
        if (pick < (draining ? 12 : 45)) begin
            r.command = CMD_ADD;
            if ($urandom_range(0, 9) == 0 && v >= 0) begin
                // same prefix as a stored route
                r.subnet = tbl_route[v].subnet;
                r.mask   = tbl_route[v].mask;
            end
            else begin
                if ($urandom_range(0, 9) == 0)
                    msk = $urandom;
                else
                    msk = (32'hFFFF_FFFF << (32 - $urandom_range(0, 32)));
                r.mask   = msk;
                r.subnet = {pick_top(), 24'($urandom)};
                // a few routes skip the masking; those with host bits set can never match
                if ($urandom_range(0, 9) != 0)
                    r.subnet &= msk;
            end
        end
        else if (pick < (draining ? 50 : 55)) begin
            r.command = CMD_REMOVE;
            if (v >= 0 && $urandom_range(0, 3) != 0)
                r.slot = 5'(v);
        end
        else if (pick < (draining ? 60 : 65)) begin
            r.command = CMD_GET;
            if (v >= 0 && $urandom_range(0, 3) != 0)
                r.slot = 5'(v);
        end
        else if (pick < (draining ? 72 : 77)) begin
            r.command = CMD_FIND;
            if (v >= 0 && $urandom_range(0, 9) < 7) begin
                r.subnet = tbl_route[v].subnet;
                r.mask   = tbl_route[v].mask;
                if ($urandom_range(0, 4) == 0)
                    r.mask = r.mask ^ (32'h1 << $urandom_range(0, 31));
            end
        end
        else if (pick < 97) begin
            r.command = CMD_LOOKUP;
            if (v >= 0 && $urandom_range(0, 3) != 0)
                r.lookup_addr = tbl_route[v].subnet | ($urandom & ~tbl_route[v].mask);
            else if ($urandom_range(0, 1) == 0)
                r.lookup_addr = {pick_top(), 24'($urandom)};
        end
        else begin
            r.command = 3'($urandom_range(5, 7));
        end
        return r;
    endfunction

    // Present one request, hold it until taken, then queue its expected result
    task automatic issue_request(input request_t r, input bit typed, input result_t want,
                                 input bit allow_gap);
        result_t predicted;
        if (allow_gap && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 36)) @(posedge clk);
        end
        request <= r;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = route_table_apply(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result checker; the receiver never stalls
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, status", 32'(result.status), 32'(ST_NONE));
            end
            else begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    flag_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.entry_index !== want.entry_index)
                    flag_mismatch("entry_index", 32'(result.entry_index), 32'(want.entry_index));
                if (result.route_subnet !== want.route_subnet)
                    flag_mismatch("route_subnet", result.route_subnet, want.route_subnet);
                if (result.route_mask !== want.route_mask)
                    flag_mismatch("route_mask", result.route_mask, want.route_mask);
                if (result.route_gateway !== want.route_gateway)
                    flag_mismatch("route_gateway", result.route_gateway, want.route_gateway);
                if (result.route_iface !== want.route_iface)
                    flag_mismatch("route_iface", 32'(result.route_iface), 32'(want.route_iface));
                if (result.route_metric !== want.route_metric)
                    flag_mismatch("route_metric", 32'(result.route_metric),
                                  32'(want.route_metric));
                if (result.match_len !== want.match_len)
                    flag_mismatch("match_len", 32'(result.match_len),
                                  32'(want.match_len));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("longest_prefix_route_table_tb: done, errors");
            $finish;
        end
    end

    initial begin
        result_t nothing;
        route_t  top_route;
        nothing   = make_res(ST_NONE, '0, '0, '0);
        top_route = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 5'd16};
        tbl_valid = '0;
        draining  = 1'b0;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;

        // Directed: empty table, bad commands, extremes, overlaps and ties
        directed_rows.push_back('{make_req(CMD_GET, '0, '0, '0, '0, '0, 5'd0, '0), 1'b1,
                                  nothing});
        directed_rows.push_back('{make_req(CMD_REMOVE, '0, '0, '0, '0, '0, 5'd31, '0), 1'b1,
                                  nothing});
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'h0), 1'b1,
                                  nothing});
        directed_rows.push_back('{make_req(CMD_FIND, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                                  nothing});
        directed_rows.push_back('{make_req(3'd5, '0, '0, '0, '0, '0, '0, '0), 1'b1, nothing});
        directed_rows.push_back('{make_req(3'd6, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                                           4'hA, 5'd10, 5'd21, 32'h5A5A_5A5A), 1'b1, nothing});
        directed_rows.push_back('{make_req(3'd7, '1, '1, '1, '1, '1, '1, '1), 1'b1, nothing});
        directed_rows.push_back('{make_req(CMD_ADD, '1, '1, '1, 4'hF, 5'd16, '0, '0), 1'b1,
                                  make_res(ST_OK, 5'd0, top_route, '0)});
        // default route lands in slot 1
        directed_rows.push_back('{make_req(CMD_ADD, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                                  make_res(ST_OK, 5'd1, '0, '0)});
        directed_rows.push_back('{make_req(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000,
                                           32'h0A00_00FE, 4'd1, 5'd1, '0, '0), 1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_ADD, 32'h0A01_0000, 32'hFFFF_0000,
                                           32'h0A01_00FE, 4'd2, 5'd2, '0, '0), 1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_ADD, 32'h0A01_0200, 32'hFFFF_FF00,
                                           32'h0A01_02FE, 4'd3, 5'd3, '0, '0), 1'b0, nothing});
        // non-contiguous mask, same length as the /16 above
        directed_rows.push_back('{make_req(CMD_ADD, 32'h0A00_0300, 32'hFF00_FF00,
                                           32'h0A00_03FE, 4'd4, 5'd4, '0, '0), 1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'h0A01_0203),
                                  1'b0, nothing});
        // tie on length: lower slot wins
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'h0A01_0305),
                                  1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'hC0A8_0001),
                                  1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF),
                                  1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_FIND, 32'h0A01_0000, 32'hFFFF_0000, '0, '0, '0,
                                           '0, '0), 1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_FIND, 32'h0A01_0000, 32'hFFFF_FF00, '0, '0, '0,
                                           '0, '0), 1'b1, nothing});
        directed_rows.push_back('{make_req(CMD_GET, '0, '0, '0, '0, '0, 5'd2, '0), 1'b0,
                                  nothing});
        directed_rows.push_back('{make_req(CMD_REMOVE, '0, '0, '0, '0, '0, 5'd1, '0), 1'b0,
                                  nothing});
        directed_rows.push_back('{make_req(CMD_GET, '0, '0, '0, '0, '0, 5'd1, '0), 1'b1,
                                  nothing});
        // default route gone: no match
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'hC0A8_0001),
                                  1'b1, nothing});
        // reuses the freed slot; mask byte 0x0F adds nothing to the length
        directed_rows.push_back('{make_req(CMD_ADD, 32'h0B00_0000, 32'hFF0F_0000,
                                           32'h1234_5678, 4'd9, 5'd15, '0, '0), 1'b0, nothing});
        directed_rows.push_back('{make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, 32'h0B30_0000),
                                  1'b0, nothing});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want,
                          1'b1);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
            issue_request(next_random_request(), 1'b0, nothing,
                          !(n >= QUIET_FIRST && n <= QUIET_LAST));
        start <= 1'b0;

        // Drain outstanding results, then let any stray one show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("longest_prefix_route_table_tb: done, clean");
        else
            $display("longest_prefix_route_table_tb: done, errors");
        $finish;
    end

endmodule
